// ===== hw/rtl/ggc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ggc_pkg;

  localparam int WINDOW_DEPTH  = 64;
  localparam int WIN_AW        = $clog2(WINDOW_DEPTH);
  localparam int FILL_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int MAX_MARKS     = 4;
  localparam int MAX_GROUPS    = 2;
  localparam int MAX_HALF_BINS = 31;
  localparam int MARK_W        = 2;
  localparam int GROUP_W       = 1;
  localparam int NB_MAX        = 2 * MAX_HALF_BINS + 1;
  localparam int HIST_DEPTH    = NB_MAX * MAX_MARKS * MAX_MARKS * MAX_GROUPS * MAX_GROUPS;
  localparam int HIST_AW       = $clog2(HIST_DEPTH);
  localparam int COUNT_WIDTH   = 32;
  localparam int TIME_W        = 32;
  localparam int BIN_W         = 16;
  localparam int HB_W          = 5;
  localparam int NB_W          = 6;
  localparam int EDGE_W        = BIN_W + NB_W;
  localparam int NUM_W         = EDGE_W + 1;
  localparam int DEN_W         = BIN_W + 1;
  localparam int Q_W           = 6;

  typedef enum logic [1:0] {
    CMD_ADD        = 2'd0,
    CMD_READ_HIST  = 2'd1,
    CMD_READ_COUNT = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_BACKWARD = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_BIN_SIZE   = 2'd0,
    REG_HALF_BINS  = 2'd1,
    REG_NUM_MARKS  = 2'd2,
    REG_NUM_GROUPS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic [MARK_W-1:0]  mark;
    logic [GROUP_W-1:0] grp;
  } win_entry_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [WIN_AW-1:0] addr;
    win_entry_t        wdata;
  } win_req_t;

  typedef struct packed {
    logic                   rd;
    logic                   wr;
    logic [HIST_AW-1:0]     addr;
    logic [COUNT_WIDTH-1:0] wdata;
  } hist_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] q;
    logic           exact;
  } div_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/grouped_cross_correlogram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming cross-correlogram of time-sorted spikes with per-group, per-mark counts.
// The input channel (s_*) carries one command per transfer in s_tuser: add a spike,
// read a histogram cell or read a spike count. The output channel (m_*) returns one
// result per command: status in m_tuser and the read value in m_tdata.
// The configuration channel (cfg_*) is always ready and writes one register per transfer.
// An added spike first drops each buffered spike that falls out of the window, then, for
// each buffered spike it is paired with, does a window memory read, a bin division and
// up to two read-modify-write increments of the histogram memory, one after the other.
// The window holds up to 64 spikes. After reset the histogram memory is swept to zero,
// one cell per cycle, over all 4032 cells; s_tready stays low during that time. Spike
// counts and window pointers clear at once. A result waits in the output register while
// the receiver stalls; the next command is still taken, and its result waits until the
// output register is free.
module grouped_cross_correlogram (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // spike_time, spike_mark, spike_group, read_index, zeros
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // count_value
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_EVAL     = 14'b00000000000010,
    S_HREAD    = 14'b00000000000100,
    S_EXP_RD   = 14'b00000000001000,
    S_EXP_CHK  = 14'b00000000010000,
    S_WALK_RD  = 14'b00000000100000,
    S_WALK_CHK = 14'b00000001000000,
    S_DIV      = 14'b00000010000000,
    S_B1_RD    = 14'b00000100000000,
    S_B1_WR    = 14'b00001000000000,
    S_B2_RD    = 14'b00010000000000,
    S_B2_WR    = 14'b00100000000000,
    S_FINISH   = 14'b01000000000000,
    S_OUT      = 14'b10000000000000
  } state_t;

  state_t state;

  logic [ggc_pkg::BIN_W-1:0] bin_size;
  logic [ggc_pkg::HB_W-1:0]  half_bins;
  logic [2:0]                num_marks;
  logic [1:0]                num_groups;

  logic [ggc_pkg::BIN_W-1:0] b_eff;
  logic [2:0]                nm;
  logic [1:0]                ng;
  logic [ggc_pkg::NB_W-1:0]  nb;
  logic [4:0]                nm_sq;
  logic [2:0]                ng_sq;
  logic [6:0]                cells;
  logic [ggc_pkg::HIST_AW-1:0] hsize;
  logic [4:0]                cnt_cells;

  logic [1:0]                   cmd_r;
  logic [ggc_pkg::TIME_W-1:0]   t_r;
  logic [2:0]                   mark_r;
  logic [1:0]                   grp_r;
  logic [11:0]                  ridx_r;

  logic [ggc_pkg::EDGE_W-1:0]   edge2;
  logic [ggc_pkg::BIN_W-1:0]    b_r;
  logic [ggc_pkg::HB_W-1:0]     h_r;
  logic [ggc_pkg::NB_W-1:0]     nb_r;
  logic [2:0]                   nm_r;
  logic [1:0]                   ng_r;
  logic [ggc_pkg::HIST_AW-1:0]  hsize_r;
  logic [ggc_pkg::MARK_W-1:0]   m1;
  logic [ggc_pkg::GROUP_W-1:0]  g1;
  logic [ggc_pkg::WIN_AW-1:0]   head;
  logic [ggc_pkg::FILL_W-1:0]   fill;
  logic [ggc_pkg::FILL_W-1:0]   k;
  logic [ggc_pkg::TIME_W-1:0]   last_time;
  logic                         le_r;
  logic                         lt_r;
  logic [ggc_pkg::HIST_AW-1:0]  base1;
  logic [ggc_pkg::HIST_AW-1:0]  base2;
  logic [ggc_pkg::HIST_AW-1:0]  addr1;
  logic [ggc_pkg::HIST_AW-1:0]  addr2;
  logic [1:0]                   res_status;
  logic [ggc_pkg::COUNT_WIDTH-1:0] res_value;
  logic [ggc_pkg::COUNT_WIDTH-1:0] spike_counts [ggc_pkg::MAX_GROUPS * ggc_pkg::MAX_MARKS];

  ggc_pkg::win_req_t   win_req;
  ggc_pkg::win_entry_t win_rdata;
  ggc_pkg::hist_req_t  hist_req;
  logic [ggc_pkg::COUNT_WIDTH-1:0] hist_rdata;
  logic                hist_busy;
  ggc_pkg::div_res_t   div_res;
  logic                div_start;
  logic [ggc_pkg::NUM_W-1:0] div_num;
  logic [ggc_pkg::DEN_W-1:0] div_den;

  logic [32:0]                 dt2;
  logic                        dt_le;
  logic                        dt_lt;
  logic [5:0]                  row_a;
  logic [5:0]                  row_b;
  logic [ggc_pkg::Q_W-1:0]     q1;
  logic [ggc_pkg::NB_W-1:0]    bin1;
  logic [ggc_pkg::NB_W-1:0]    bin2;
  logic                        go1;
  logic                        go2;
  logic                        mark_ok;
  logic                        hist_ok;
  logic [3:0]                  r4;
  logic [3:0]                  gid4;
  logic [1:0]                  cm;
  logic                        cg;
  logic                        out_free;

  assign s_tready  = (state == S_IDLE) && !hist_busy;
  assign cfg_ready = 1'b1;

  assign b_eff     = (bin_size == '0) ? ggc_pkg::BIN_W'(1) : bin_size;
  assign nm        = (num_marks > 3'(ggc_pkg::MAX_MARKS)) ? 3'(ggc_pkg::MAX_MARKS) : num_marks;
  assign ng        = (num_groups > 2'(ggc_pkg::MAX_GROUPS)) ? 2'(ggc_pkg::MAX_GROUPS)
                                                            : num_groups;
  assign nb        = {half_bins, 1'b1};
  assign nm_sq     = 5'(nm) * 5'(nm);
  assign ng_sq     = 3'(ng) * 3'(ng);
  assign cells     = 7'(nm_sq) * 7'(ng_sq);
  assign hsize     = ggc_pkg::HIST_AW'(nb) * ggc_pkg::HIST_AW'(cells);
  assign cnt_cells = 5'(nm) * 5'(ng_sq);

  assign mark_ok = (mark_r >= 3'd1) && (mark_r <= nm) && (grp_r >= 2'd1) && (grp_r <= ng);
  assign hist_ok = (ridx_r < hsize);

  // Spike count cell: group (i/nm)/ng, mark i%nm.
  assign r4 = ridx_r[3:0];
  always_comb begin
    gid4 = '0;
    cm   = '0;
    unique case (nm)
      3'd1: begin
        gid4 = r4;
      end
      3'd2: begin
        gid4 = r4 >> 1;
        cm   = {1'b0, r4[0]};
      end
      3'd3: begin
        if (r4 >= 4'd9) begin
          gid4 = 4'd3;
        end else if (r4 >= 4'd6) begin
          gid4 = 4'd2;
        end else if (r4 >= 4'd3) begin
          gid4 = 4'd1;
        end
        cm = 2'(r4 - 4'(gid4 * 4'd3));
      end
      3'd4: begin
        gid4 = r4 >> 2;
        cm   = r4[1:0];
      end
      default: begin
        gid4 = '0;
        cm   = '0;
      end
    endcase
  end
  assign cg = (ng == 2'd2) && gid4[1];

  assign dt2   = {t_r - win_rdata.stamp, 1'b0};
  assign dt_le = (dt2 <= 33'(edge2));
  assign dt_lt = (dt2 < 33'(edge2));

  assign row_a = 6'(((6'(g1) * 6'(ng_r) + 6'(win_rdata.grp)) * 6'(nm_r) + 6'(m1)) * 6'(nm_r)
                    + 6'(win_rdata.mark));
  assign row_b = 6'(((6'(win_rdata.grp) * 6'(ng_r) + 6'(g1)) * 6'(nm_r)
                    + 6'(win_rdata.mark)) * 6'(nm_r) + 6'(m1));

  assign q1   = div_res.q - ggc_pkg::Q_W'(div_res.exact);
  assign bin1 = ggc_pkg::NB_W'(h_r) - q1;
  assign bin2 = ggc_pkg::NB_W'(h_r) + div_res.q;

  assign go1 = le_r && (addr1 < hsize_r);
  assign go2 = lt_r && (addr2 < hsize_r);

  assign div_start = (state == S_WALK_CHK) && dt_le;
  assign div_num   = ggc_pkg::NUM_W'(dt2) + ggc_pkg::NUM_W'(b_r);
  assign div_den   = {b_r, 1'b0};

  always_comb begin
    win_req       = '0;
    win_req.wdata = '{stamp: t_r, mark: m1, grp: g1};
    unique case (state)
      S_EXP_RD: begin
        win_req.rd   = (fill != '0);
        win_req.addr = head;
      end
      S_WALK_RD: begin
        win_req.rd   = (k != fill);
        win_req.addr = head + k[ggc_pkg::WIN_AW-1:0];
      end
      S_FINISH: begin
        win_req.wr   = 1'b1;
        win_req.addr = head + fill[ggc_pkg::WIN_AW-1:0];
      end
      default: begin
        win_req.rd = 1'b0;
      end
    endcase
  end

  always_comb begin
    hist_req       = '0;
    hist_req.wdata = hist_rdata + 1'b1;
    unique case (state)
      S_EVAL: begin
        hist_req.rd   = (cmd_r == ggc_pkg::CMD_READ_HIST) && hist_ok;
        hist_req.addr = ridx_r;
      end
      S_B1_RD: begin
        hist_req.rd   = go1;
        hist_req.addr = addr1;
      end
      S_B1_WR: begin
        hist_req.wr   = 1'b1;
        hist_req.addr = addr1;
      end
      S_B2_RD: begin
        hist_req.rd   = go2;
        hist_req.addr = addr2;
      end
      S_B2_WR: begin
        hist_req.wr   = 1'b1;
        hist_req.addr = addr2;
      end
      default: begin
        hist_req.rd = 1'b0;
      end
    endcase
  end

  ggc_window u_window (
    .clk   (clk),
    .req   (win_req),
    .rdata (win_rdata)
  );

  ggc_hist u_hist (
    .clk   (clk),
    .rst   (rst),
    .req   (hist_req),
    .rdata (hist_rdata),
    .busy  (hist_busy)
  );

  ggc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_size   <= ggc_pkg::BIN_W'(1);
      half_bins  <= '0;
      num_marks  <= 3'd4;
      num_groups <= 2'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ggc_pkg::REG_BIN_SIZE:   bin_size   <= cfg_data;
        ggc_pkg::REG_HALF_BINS:  half_bins  <= cfg_data[ggc_pkg::HB_W-1:0];
        ggc_pkg::REG_NUM_MARKS:  num_marks  <= cfg_data[2:0];
        ggc_pkg::REG_NUM_GROUPS: num_groups <= cfg_data[1:0];
        default:                 bin_size   <= bin_size;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      fill      <= '0;
      last_time <= '0;
      for (int i = 0; i < ggc_pkg::MAX_GROUPS * ggc_pkg::MAX_MARKS; i++) begin
        spike_counts[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            cmd_r  <= s_tuser;
            t_r    <= s_tdata[31:0];
            mark_r <= s_tdata[34:32];
            grp_r  <= s_tdata[36:35];
            ridx_r <= s_tdata[48:37];
            state  <= S_EVAL;
          end
        end
        S_EVAL: begin
          edge2      <= ggc_pkg::EDGE_W'(b_eff) * ggc_pkg::EDGE_W'(nb);
          b_r        <= b_eff;
          h_r        <= half_bins;
          nb_r       <= nb;
          nm_r       <= nm;
          ng_r       <= ng;
          hsize_r    <= hsize;
          m1         <= ggc_pkg::MARK_W'(mark_r - 3'd1);
          g1         <= ggc_pkg::GROUP_W'(grp_r - 2'd1);
          unique case (cmd_r)
            ggc_pkg::CMD_ADD: begin
              res_value <= '0;
              if (!mark_ok) begin
                res_status <= ggc_pkg::ST_RANGE;
                state      <= S_OUT;
              end else if (t_r < last_time) begin
                res_status <= ggc_pkg::ST_BACKWARD;
                state      <= S_OUT;
              end else begin
                res_status <= ggc_pkg::ST_OK;
                state      <= S_EXP_RD;
              end
            end
            ggc_pkg::CMD_READ_HIST: begin
              res_value <= '0;
              if (hist_ok) begin
                res_status <= ggc_pkg::ST_OK;
                state      <= S_HREAD;
              end else begin
                res_status <= ggc_pkg::ST_RANGE;
                state      <= S_OUT;
              end
            end
            ggc_pkg::CMD_READ_COUNT: begin
              if (ridx_r < 12'(cnt_cells)) begin
                res_status <= ggc_pkg::ST_OK;
                res_value  <= spike_counts[{cg, cm}];
              end else begin
                res_status <= ggc_pkg::ST_RANGE;
                res_value  <= '0;
              end
              state <= S_OUT;
            end
            default: begin
              res_status <= ggc_pkg::ST_OK;
              res_value  <= '0;
              state      <= S_OUT;
            end
          endcase
        end
        S_HREAD: begin
          res_value <= hist_rdata;
          state     <= S_OUT;
        end
        S_EXP_RD: begin
          k <= '0;
          if (fill == '0) begin
            state <= S_FINISH;
          end else begin
            state <= S_EXP_CHK;
          end
        end
        S_EXP_CHK: begin
          if (!dt_le) begin
            head  <= head + 1'b1;
            fill  <= fill - 1'b1;
            state <= S_EXP_RD;
          end else begin
            state <= S_WALK_RD;
          end
        end
        S_WALK_RD: begin
          if (k == fill) begin
            state <= S_FINISH;
          end else begin
            state <= S_WALK_CHK;
          end
        end
        S_WALK_CHK: begin
          if (!dt_le) begin
            k     <= k + 1'b1;
            state <= S_WALK_RD;
          end else begin
            le_r  <= dt_le;
            lt_r  <= dt_lt;
            base1 <= ggc_pkg::HIST_AW'(nb_r) * ggc_pkg::HIST_AW'(row_a);
            base2 <= ggc_pkg::HIST_AW'(nb_r) * ggc_pkg::HIST_AW'(row_b);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            addr1 <= base1 + ggc_pkg::HIST_AW'(bin1);
            addr2 <= base2 + ggc_pkg::HIST_AW'(bin2);
            state <= S_B1_RD;
          end
        end
        S_B1_RD: begin
          state <= go1 ? S_B1_WR : S_B2_RD;
        end
        S_B1_WR: begin
          state <= S_B2_RD;
        end
        S_B2_RD: begin
          if (go2) begin
            state <= S_B2_WR;
          end else begin
            k     <= k + 1'b1;
            state <= S_WALK_RD;
          end
        end
        S_B2_WR: begin
          k     <= k + 1'b1;
          state <= S_WALK_RD;
        end
        S_FINISH: begin
          for (int i = 0; i < ggc_pkg::MAX_GROUPS * ggc_pkg::MAX_MARKS; i++) begin
            if (3'(i) == {g1, m1}) begin
              spike_counts[i] <= spike_counts[i] + 1'b1;
            end
          end
          if (fill == ggc_pkg::FILL_W'(ggc_pkg::WINDOW_DEPTH)) begin
            head       <= head + 1'b1;
            res_status <= ggc_pkg::ST_OVERFLOW;
          end else begin
            fill <= fill + 1'b1;
          end
          last_time <= t_r;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_tuser  <= res_status;
            m_tdata  <= res_value;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ggc_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ggc_window (
  input  logic                clk,
  input  ggc_pkg::win_req_t   req,
  output ggc_pkg::win_entry_t rdata
);

  ggc_pkg::win_entry_t mem [ggc_pkg::WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ggc_hist.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ggc_hist (
  input  logic                                clk,
  input  logic                                rst,
  input  ggc_pkg::hist_req_t                  req,
  output logic [ggc_pkg::COUNT_WIDTH-1:0]     rdata,
  output logic                                busy
);

  logic [ggc_pkg::COUNT_WIDTH-1:0] mem [ggc_pkg::HIST_DEPTH];
  logic [ggc_pkg::HIST_AW-1:0]     clr_addr;

  // The clearing sweep walks every cell once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == ggc_pkg::HIST_AW'(ggc_pkg::HIST_DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ggc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ggc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ggc_pkg::NUM_W-1:0]   num,
  input  logic [ggc_pkg::DEN_W-1:0]   den,
  output ggc_pkg::div_res_t           res
);

  logic [ggc_pkg::NUM_W-1:0] rem;
  logic [ggc_pkg::DEN_W-1:0] dv;
  logic [ggc_pkg::Q_W-1:0]   q;
  logic [2:0]                step;
  logic                      run;
  logic                      done;
  logic [ggc_pkg::NUM_W-1:0] cand;

  assign cand = ggc_pkg::NUM_W'(dv) << step;

  // Restoring division, one quotient bit per cycle, most significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && run && (step == 3'd0);
      if (start) begin
        run  <= 1'b1;
        rem  <= num;
        dv   <= den;
        q    <= '0;
        step <= 3'(ggc_pkg::Q_W - 1);
      end else if (run) begin
        if (rem >= cand) begin
          rem     <= rem - cand;
          q[step] <= 1'b1;
        end
        if (step == 3'd0) begin
          run <= 1'b0;
        end
        step <= step - 3'd1;
      end
    end
  end

  assign res.done  = done;
  assign res.q     = q;
  assign res.exact = (rem == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/ggc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ggc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // No result is pending right after reset.
  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // The histogram sweep after reset holds off new commands.
  a_reset_busy: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("command taken during clearing sweep");

  // Commands are taken one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command taken while another is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Any non-ok status carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ggc_pkg::ST_OK) |-> (m_tdata == '0))
    else $error("non-zero value with error status");

endmodule

bind grouped_cross_correlogram ggc_checker u_ggc_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ggc_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  class correlogram_scoreboard;
    int unsigned bin_size, half_bins, num_marks, num_groups;
    logic [31:0] win_time [WINDOW_DEPTH];
    int unsigned win_mark [WINDOW_DEPTH];
    int unsigned win_grp [WINDOW_DEPTH];
    int unsigned head, fill;
    logic [31:0] last_time;
    logic [31:0] hist [HIST_DEPTH];
    logic [31:0] counts [MAX_GROUPS*MAX_MARKS];
    status_t exp_status [$];
    logic [31:0] exp_value [$];
    int errors;

    function new();
      bin_size = 1;
      half_bins = 0;
      num_marks = 4;
      num_groups = 1;
      head = 0;
      fill = 0;
      last_time = 0;
      errors = 0;
      foreach (hist[i]) hist[i] = '0;
      foreach (counts[i]) counts[i] = '0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] d);
      case (idx)
        REG_BIN_SIZE:   bin_size = d;
        REG_HALF_BINS:  half_bins = d[4:0];
        REG_NUM_MARKS:  num_marks = d[2:0];
        REG_NUM_GROUPS: num_groups = d[1:0];
      endcase
    endfunction

    function int unsigned marks_used();
      return (num_marks > MAX_MARKS) ? MAX_MARKS : num_marks;
    endfunction

    function int unsigned groups_used();
      return (num_groups > MAX_GROUPS) ? MAX_GROUPS : num_groups;
    endfunction

    function int unsigned hist_size();
      int unsigned h;
      h = (half_bins > MAX_HALF_BINS) ? MAX_HALF_BINS : half_bins;
      return (2*h + 1) * marks_used() * marks_used() * groups_used() * groups_used();
    endfunction

    function void bump(longint unsigned idx, longint unsigned hsize);
      if (idx < hsize && idx < HIST_DEPTH) hist[idx] = hist[idx] + 1;
    endfunction

    function void note_command(cmd_t c, logic [31:0] t, logic [2:0] mark, logic [1:0] grp,
                               logic [11:0] ridx);
      longint unsigned b, h, nm, ng, nb, hsize, edge2, dt2, bin, m1, g1, m2, g2;
      int unsigned slot;
      status_t st;
      logic [31:0] val;
      b = (bin_size == 0) ? 1 : bin_size;
      h = (half_bins > MAX_HALF_BINS) ? MAX_HALF_BINS : half_bins;
      nm = marks_used();
      ng = groups_used();
      nb = 2*h + 1;
      hsize = nb * nm * nm * ng * ng;
      edge2 = b * nb;
      st = ST_OK;
      val = '0;
      case (c)
        CMD_ADD: begin
          if (mark < 1 || mark > nm || grp < 1 || grp > ng) begin
            st = ST_RANGE;
          end else if (t < last_time) begin
            st = ST_BACKWARD;
          end else begin
            m1 = mark - 1;
            g1 = grp - 1;
            while (fill > 0 && 2 * longint'(32'(t - win_time[head])) > edge2) begin
              head = (head + 1) % WINDOW_DEPTH;
              fill--;
            end
            for (int k = 0; k < fill; k++) begin
              slot = (head + k) % WINDOW_DEPTH;
              dt2 = 2 * longint'(32'(t - win_time[slot]));
              m2 = win_mark[slot];
              g2 = win_grp[slot];
              if (dt2 <= edge2) begin
                bin = h - (dt2 + b - 1) / (2*b);
                bump(nb*nm*nm*(g1*ng + g2) + nb*nm*m1 + nb*m2 + bin, hsize);
              end
              if (dt2 < edge2) begin
                bin = h + (dt2 + b) / (2*b);
                bump(nb*nm*nm*(g2*ng + g1) + nb*nm*m2 + nb*m1 + bin, hsize);
              end
            end
            counts[g1*MAX_MARKS + m1] = counts[g1*MAX_MARKS + m1] + 1;
            slot = (head + fill) % WINDOW_DEPTH;
            win_time[slot] = t;
            win_mark[slot] = m1;
            win_grp[slot] = g1;
            if (fill >= WINDOW_DEPTH) begin
              head = (head + 1) % WINDOW_DEPTH;
              st = ST_OVERFLOW;
            end else begin
              fill++;
            end
            last_time = t;
          end
        end
        CMD_READ_HIST: begin
          if (ridx < hsize && ridx < HIST_DEPTH) val = hist[ridx];
          else st = ST_RANGE;
        end
        CMD_READ_COUNT: begin
          if (ridx < nm * ng * ng) val = counts[((ridx / nm) / ng) * MAX_MARKS + ridx % nm];
          else st = ST_RANGE;
        end
        default: ;
      endcase
      exp_status.push_back(st);
      exp_value.push_back(val);
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] v);
      status_t es;
      logic [31:0] ev;
      if (exp_status.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d value %h", $time, st, v);
        errors++;
        return;
      end
      es = exp_status.pop_front();
      ev = exp_value.pop_front();
      if (st !== es) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, es, st);
        errors++;
      end
      if (v !== ev) begin
        $display("%0t: count mismatch: expected %h actual %h", $time, ev, v);
        errors++;
      end
    endfunction

    function int pending();
      return exp_status.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  correlogram_scoreboard sb;
  longint unsigned spike_clock;
  int cycles;

  grouped_cross_correlogram uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[grouped_cross_correlogram] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  // Output backpressure: random stalls in changing moods, plus one long hold-off.
  int results_seen;
  int stall_left;
  int stall_pct;
  bit held_off;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) results_seen <= results_seen + 1;
      if (cycles % 500 == 0) stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
      if (!held_off && results_seen == 400) begin
        held_off <= 1'b1;
        stall_left <= 4000;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 299) == 0) begin
        stall_left <= $urandom_range(20, 100);
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(cmd_t c, logic [31:0] t, logic [2:0] m, logic [1:0] g,
                           logic [11:0] r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c;
    s_tdata <= {7'd0, r, g, m, t};
    do @(posedge clk); while (!s_tready);
    sb.note_command(c, t, m, g, r);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_layout(logic [15:0] b, logic [15:0] h, logic [15:0] m, logic [15:0] g);
    logic [15:0] vals [4];
    reg_idx_t idx [4];
    vals = '{b, h, m, g};
    idx = '{REG_BIN_SIZE, REG_HALF_BINS, REG_NUM_MARKS, REG_NUM_GROUPS};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic add_spike(int unsigned max_step);
    longint unsigned step;
    int unsigned nm, ng;
    logic [2:0] m;
    logic [1:0] g;
    nm = sb.marks_used();
    ng = sb.groups_used();
    step = $urandom_range(0, max_step);
    if ($urandom_range(0, 99) == 0) step += $urandom_range(0, 1 << 28);
    m = (nm == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, nm));
    g = (ng == 0) ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, ng));
    spike_clock = spike_clock + step;
    if (spike_clock > 64'hFFFF_FFFF) spike_clock = 64'hFFFF_FFFF;
    send_item(CMD_ADD, spike_clock[31:0], m, g, 12'($urandom));
  endtask

  task automatic run_phase(int n, int unsigned max_step);
    int r;
    int unsigned nm, ng, hs;
    logic [2:0] m;
    logic [1:0] g;
    logic [11:0] idx;
    for (int i = 0; i < n; i++) begin
      nm = sb.marks_used();
      ng = sb.groups_used();
      hs = sb.hist_size();
      r = $urandom_range(0, 99);
      if (r < 62) begin
        add_spike(max_step);
      end else if (r < 70) begin
        m = 3'($urandom_range(1, 4));
        g = 2'($urandom_range(1, 2));
        case ($urandom_range(0, 2))
          0: do m = 3'($urandom_range(0, 7)); while (m >= 1 && m <= nm);
          1: do g = 2'($urandom_range(0, 3)); while (g >= 1 && g <= ng);
          default: ;
        endcase
        if (spike_clock > 0 && m >= 1 && m <= nm && g >= 1 && g <= ng)
          send_item(CMD_ADD, 32'(spike_clock - 1 - $urandom_range(0, 1000) % spike_clock),
                    m, g, 12'($urandom));
        else
          send_item(CMD_ADD, $urandom, m, g, 12'($urandom));
      end else if (r < 88) begin
        idx = ($urandom_range(0, 9) == 0 || hs == 0) ? 12'($urandom) :
              12'($urandom_range(0, hs - 1));
        send_item(CMD_READ_HIST, $urandom, 3'($urandom), 2'($urandom), idx);
      end else if (r < 97) begin
        idx = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 9));
        send_item(CMD_READ_COUNT, $urandom, 3'($urandom), 2'($urandom), idx);
      end else begin
        send_item(CMD_NONE, $urandom, 3'($urandom), 2'($urandom), 12'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    results_seen = 0;
    stall_left = 0;
    stall_pct = 0;
    held_off = 1'b0;
    spike_clock = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_NONE;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_BIN_SIZE;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_ADD, 32'd0, 3'd1, 2'd1, 12'd0);
    send_item(CMD_ADD, 32'd0, 3'd4, 2'd1, 12'd0);
    send_item(CMD_ADD, 32'd1, 3'd2, 2'd1, 12'd0);
    send_item(CMD_ADD, 32'd5, 3'd0, 2'd1, 12'd0);
    send_item(CMD_ADD, 32'd5, 3'd7, 2'd1, 12'd0);
    send_item(CMD_ADD, 32'd5, 3'd1, 2'd0, 12'd0);
    send_item(CMD_ADD, 32'd5, 3'd1, 2'd3, 12'd0);
    send_item(CMD_ADD, 32'd5, 3'd3, 2'd1, 12'd0);
    send_item(CMD_ADD, 32'd3, 3'd3, 2'd1, 12'd0);
    send_item(CMD_READ_HIST, 32'd0, 3'd0, 2'd0, 12'd0);
    send_item(CMD_READ_HIST, 32'd0, 3'd0, 2'd0, 12'd3);
    send_item(CMD_READ_HIST, 32'd0, 3'd0, 2'd0, 12'd15);
    send_item(CMD_READ_HIST, 32'd0, 3'd0, 2'd0, 12'd16);
    send_item(CMD_READ_HIST, 32'hFFFF_FFFF, 3'd7, 2'd3, 12'hFFF);
    for (int i = 0; i < 5; i++)
      send_item(CMD_READ_COUNT, 32'd0, 3'd0, 2'd0, 12'(i));
    send_item(CMD_NONE, 32'hFFFF_FFFF, 3'd7, 2'd3, 12'hFFF);
    spike_clock = 5;

    set_layout(16'd0, 16'd31, 16'd4, 16'd2);
    run_phase(250, 40);
    set_layout(16'hFFFF, 16'hFFFF, 16'd7, 16'd3);
    run_phase(120, 20);
    set_layout(16'd3, 16'd5, 16'd2, 16'd2);
    run_phase(250, 15);
    set_layout(16'd1, 16'd0, 16'd1, 16'd1);
    run_phase(200, 2);
    set_layout(16'd7, 16'd2, 16'd4, 16'd2);
    run_phase(250, 30);
    set_layout(16'd5, 16'd3, 16'd0, 16'd1);
    run_phase(30, 10);
    set_layout(16'd2, 16'd1, 16'd3, 16'd0);
    run_phase(30, 5);
    set_layout(16'd100, 16'd10, 16'd4, 16'd2);
    run_phase(250, 1500);
    set_layout(16'd9, 16'd31, 16'd4, 16'd2);
    if (spike_clock < 64'hFFFF_FF00) spike_clock = 64'hFFFF_FF00;
    run_phase(350, 10);

    wait_drained();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[grouped_cross_correlogram] OK");
    end else begin
      $display("[grouped_cross_correlogram] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ggc_pkg.sv
hw/rtl/ggc_window.sv
hw/rtl/ggc_hist.sv
hw/rtl/ggc_div.sv
hw/rtl/grouped_cross_correlogram.sv
hw/rtl/ggc_checker.sv
tb/testbench.sv
